### rtl/huffman_bit_packer_assert.svh
// Assertion macros shared by the packer RTL.
`ifndef HUFFMAN_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_BIT_PACKER_ASSERT_SVH

// Plain invariant, checked at every rising clock edge outside reset.
`define HBP_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define HBP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### rtl/hbp_pkg.sv
package hbp_pkg;

   // Table geometry
   localparam int MAX_CODE_LEN = 32;
   localparam int SYMBOL_COUNT = 256;
   localparam int LEN_CAP      = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
   localparam int SYM_W        = 8;
   localparam int CODE_W       = 32;
   localparam int LEN_W        = 6;
   localparam int SYM_ADDR_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int ENTRY_W      = CODE_W + LEN_W;

   // Result queue geometry; depth is a power of two so pointers wrap on their own
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1) + 1;

   typedef logic [Q_PTR_W-1:0] q_ptr_type;
   typedef logic [Q_CNT_W-1:0] q_cnt_type;

   // Operation codes
   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

endpackage

### rtl/hbp_if.sv
// Request channel: one table load, encode or flush per beat.
interface hbp_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     operation;
   logic [hbp_pkg::SYM_W-1:0]      symbol;
   logic [hbp_pkg::CODE_W-1:0]     code_bits;
   logic [hbp_pkg::LEN_W-1:0]      code_length;

   modport source (output valid, operation, symbol, code_bits, code_length, input ready);
   modport sink   (input valid, operation, symbol, code_bits, code_length, output ready);
endinterface

// Response channel: one packed byte per beat.
interface hbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);
endinterface

### rtl/huffman_bit_packer.sv
// Path: an encode or flush passes the registered code table read, then packing into
//   the result queue, before its first byte is shown.
// Throughput: one request per cycle; one response byte per cycle while ready. Requests
//   stall only while the four-entry result queue cannot take another item's bytes.
// Reset clears the pending byte, bit count, pipeline and queue; the code table is not
//   cleared and each entry must be loaded before it is encoded.
`include "huffman_bit_packer_assert.svh"

module huffman_bit_packer (
   input  logic      clock,
   input  logic      reset,
   hbp_req_if.sink   req_ch,
   hbp_rsp_if.source rsp_ch
);

   // One queue entry holds all bytes caused by one request
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      nres;
   } entry_type;

   // ---------------------------------------------------------------------------
   // Request side: table write and read issue
   // ---------------------------------------------------------------------------
   logic                             req_accept;
   logic                             req_sym_ok;
   logic [hbp_pkg::LEN_W-1:0]        load_len;
   logic [63:0]                      load_mask;
   logic [hbp_pkg::CODE_W-1:0]       load_code;
   logic [hbp_pkg::ENTRY_W-1:0]      tbl_rd_data;
   logic [hbp_pkg::CODE_W-1:0]       tbl_code;
   logic [hbp_pkg::LEN_W-1:0]        tbl_len;

   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_op_ff, s1_op_in;
   logic       s1_sym_ok_ff, s1_sym_ok_in;

   hbp_pkg::q_cnt_type q_count_ff, q_count_in;

   assign req_ch.ready = (q_count_ff + hbp_pkg::q_cnt_type'(s1_valid_ff))
                         < hbp_pkg::q_cnt_type'(hbp_pkg::Q_DEPTH);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign req_sym_ok   = {1'b0, req_ch.symbol} < 9'(hbp_pkg::SYMBOL_COUNT);

   // Saturate the length and drop code bits above it
   always_comb begin
      if (req_ch.code_length > 6'(hbp_pkg::LEN_CAP)) begin
         load_len = 6'(hbp_pkg::LEN_CAP);
      end else begin
         load_len = req_ch.code_length;
      end
      load_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << load_len);
      load_code = req_ch.code_bits & load_mask[hbp_pkg::CODE_W-1:0];
   end

   hbp_ram #(
      .WIDTH (hbp_pkg::ENTRY_W),
      .DEPTH (hbp_pkg::SYMBOL_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (req_accept && (req_ch.operation == hbp_pkg::OP_LOAD) && req_sym_ok),
      .wr_addr (req_ch.symbol[hbp_pkg::SYM_ADDR_W-1:0]),
      .wr_data ({load_len, load_code}),
      .rd_en   (req_accept && (req_ch.operation == hbp_pkg::OP_ENCODE)),
      .rd_addr (req_ch.symbol[hbp_pkg::SYM_ADDR_W-1:0]),
      .rd_data (tbl_rd_data)
   );

   assign tbl_code = tbl_rd_data[hbp_pkg::CODE_W-1:0];
   assign tbl_len  = tbl_rd_data[hbp_pkg::ENTRY_W-1:hbp_pkg::CODE_W];

   // Stage 1 control register
   always_comb begin
      s1_valid_in  = req_accept;
      s1_op_in     = req_ch.operation;
      s1_sym_ok_in = req_sym_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_op_ff     <= s1_op_in;
      s1_sym_ok_ff <= s1_sym_ok_in;
   end

   // ---------------------------------------------------------------------------
   // Stage 1: bit packing
   // ---------------------------------------------------------------------------
   logic [7:0]  pend_byte_ff, pend_byte_in;
   logic [2:0]  pend_cnt_ff, pend_cnt_in;
   logic [31:0] code_left;
   logic [39:0] pack_win;
   logic [5:0]  pack_total;
   logic [2:0]  pack_nbytes;
   logic [7:0]  pack_rest;
   entry_type   s1_entry;
   logic        s1_push;

   always_comb begin
      // Left-align the code, then slide it behind the pending bits
      code_left   = tbl_code << (6'd32 - tbl_len);
      pack_win    = {pend_byte_ff, 32'd0} | ({code_left, 8'd0} >> pend_cnt_ff);
      pack_total  = {3'b000, pend_cnt_ff} + tbl_len;
      pack_nbytes = pack_total[5:3];
      case (pack_nbytes)
         3'd0:    pack_rest = pack_win[39:32];
         3'd1:    pack_rest = pack_win[31:24];
         3'd2:    pack_rest = pack_win[23:16];
         3'd3:    pack_rest = pack_win[15:8];
         3'd4:    pack_rest = pack_win[7:0];
         default: pack_rest = 8'd0;
      endcase

      s1_entry.bytes[0] = pack_win[39:32];
      s1_entry.bytes[1] = pack_win[31:24];
      s1_entry.bytes[2] = pack_win[23:16];
      s1_entry.bytes[3] = pack_win[15:8];
      s1_entry.nres     = 3'd0;
      pend_byte_in      = pend_byte_ff;
      pend_cnt_in       = pend_cnt_ff;

      if (s1_valid_ff) begin
         case (s1_op_ff)
            hbp_pkg::OP_ENCODE: begin
               if (s1_sym_ok_ff) begin
                  s1_entry.nres = pack_nbytes;
                  pend_byte_in  = pack_rest;
                  pend_cnt_in   = pack_total[2:0];
               end
            end
            hbp_pkg::OP_FLUSH: begin
               // Padded pending byte, then its bit count
               s1_entry.bytes[0] = pend_byte_ff;
               s1_entry.bytes[1] = {5'd0, pend_cnt_ff};
               s1_entry.nres     = 3'd2;
               pend_byte_in      = 8'd0;
               pend_cnt_in       = 3'd0;
            end
            default: begin
               s1_entry.nres = 3'd0;
            end
         endcase
      end
      s1_push = s1_entry.nres != 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_byte_ff <= 8'd0;
         pend_cnt_ff  <= 3'd0;
      end else begin
         pend_byte_ff <= pend_byte_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Result queue and byte sequencer
   // ---------------------------------------------------------------------------
   entry_type          q_mem_ff [hbp_pkg::Q_DEPTH];
   hbp_pkg::q_ptr_type wr_ptr_ff, wr_ptr_in;
   hbp_pkg::q_ptr_type rd_ptr_ff, rd_ptr_in;
   logic [1:0]         idx_ff, idx_in;
   entry_type          head;
   logic [2:0]         head_last;
   logic               rsp_beat;
   logic               entry_done;

   assign head      = q_mem_ff[rd_ptr_ff];
   assign head_last = head.nres - 3'd1;

   assign rsp_ch.valid    = q_count_ff != '0;
   assign rsp_ch.out_byte = head.bytes[idx_ff];
   assign rsp_ch.last     = {1'b0, idx_ff} == head_last;

   always_comb begin
      rsp_beat   = rsp_ch.valid && rsp_ch.ready;
      entry_done = rsp_beat && rsp_ch.last;
      wr_ptr_in  = s1_push ? wr_ptr_ff + hbp_pkg::q_ptr_type'(1) : wr_ptr_ff;
      rd_ptr_in  = entry_done ? rd_ptr_ff + hbp_pkg::q_ptr_type'(1) : rd_ptr_ff;
      q_count_in = q_count_ff + hbp_pkg::q_cnt_type'(s1_push)
                   - hbp_pkg::q_cnt_type'(entry_done);
      if (entry_done) begin
         idx_in = 2'd0;
      end else if (rsp_beat) begin
         idx_in = idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
         idx_ff     <= 2'd0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
         idx_ff     <= idx_in;
      end
      if (s1_push) begin
         q_mem_ff[wr_ptr_ff] <= s1_entry;
      end
   end

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   `HBP_ASSERT(a_q_bound, q_count_ff <= hbp_pkg::q_cnt_type'(hbp_pkg::Q_DEPTH), "queue count")
   `HBP_ASSERT_IMP(a_push_room, s1_push, q_count_ff < hbp_pkg::q_cnt_type'(hbp_pkg::Q_DEPTH), "full")
   `HBP_ASSERT(a_pend_clean, (pend_byte_ff & (8'hFF >> pend_cnt_ff)) == 8'd0, "stray pending bits")
   `HBP_ASSERT_IMP(a_head_nonempty, rsp_ch.valid, head.nres != 3'd0, "empty entry at head")
   `HBP_ASSERT_IMP(a_idx_range, rsp_ch.valid, 3'(idx_ff) <= head_last, "byte index past entry")

endmodule

### rtl/hbp_ram.sv
// Simple dual-port RAM, one write port, one registered read port.
module hbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         N_ITEMS     = 430;
   localparam int         N_STEADY    = 50;
   localparam int         HOLD_CYCLES = 120;
   localparam int         HOLD_AFTER  = 60;
   localparam int         IDLE_LIMIT  = 1000;
   localparam int         DRAIN_WAIT  = 20;

   typedef logic [hbp_pkg::SYM_W-1:0]  sym_type;
   typedef logic [hbp_pkg::CODE_W-1:0] code_type;
   typedef logic [hbp_pkg::LEN_W-1:0]  len_type;

   // One request beat as queued for the driver
   typedef struct {
      logic [1:0] op;
      sym_type    sym;
      code_type   code;
      len_type    len;
      logic       steady;
   } req_beat_type;

   // One response beat as predicted
   typedef struct {
      logic [7:0] data;
      logic       last;
   } packed_byte_type;

   logic clock;
   logic reset;

   hbp_req_if req_ch ();
   hbp_rsp_if rsp_ch ();

   huffman_bit_packer uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Stimulus and expectation stores
   req_beat_type    request_q[$];
   packed_byte_type packed_q[$];

   // Shadow of the packer state
   code_type   code_mem [hbp_pkg::SYMBOL_COUNT];
   int         len_mem  [hbp_pkg::SYMBOL_COUNT];
   logic [7:0] fill_byte;
   int         fill_cnt;

   // Generation-time view of which table entries hold a code
   bit         gen_written [hbp_pkg::SYMBOL_COUNT];
   sym_type    loaded_syms[$];

   int  mismatches;
   int  beats_out;
   int  idle_cycles;
   int  jitter_pct;
   int  jitter_cyc;
   bit  steady_mode;
   bit  offering;
   int  req_gap;
   int  rsp_stall;
   int  hold_cnt;
   bit  hold_done;

   always #2 clock = ~clock;

   task automatic flag_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatches++;
   endtask

   // Bit packer prediction for one accepted request beat
   task automatic pack_request(input req_beat_type rq);
      code_type bits;
      int       len;
      int       nb;
      case (rq.op)
         hbp_pkg::OP_LOAD: begin
            if (rq.sym < hbp_pkg::SYMBOL_COUNT) begin
               len = rq.len;
               if (len > hbp_pkg::LEN_CAP) len = hbp_pkg::LEN_CAP;
               bits = rq.code;
               if (len < 32) bits = bits & ((32'h1 << len) - 32'h1);
               code_mem[rq.sym] = bits;
               len_mem[rq.sym]  = len;
            end
         end
         hbp_pkg::OP_ENCODE: begin
            if (rq.sym < hbp_pkg::SYMBOL_COUNT) begin
               bits = code_mem[rq.sym];
               len  = len_mem[rq.sym];
               if (len > hbp_pkg::LEN_CAP) len = hbp_pkg::LEN_CAP;
               nb = 0;
               // code goes out first bit first, filling bit 7 down to bit 0
               for (int k = len - 1; k >= 0; k--) begin
                  if (bits[k]) fill_byte[7 - fill_cnt] = 1'b1;
                  fill_cnt++;
                  if (fill_cnt == 8) begin
                     packed_q.push_back(packed_byte_type'{fill_byte, 1'b0});
                     nb++;
                     fill_byte = '0;
                     fill_cnt  = 0;
                  end
               end
               if (nb > 0) packed_q[$].last = 1'b1;
            end
         end
         hbp_pkg::OP_FLUSH: begin
            packed_q.push_back(packed_byte_type'{fill_byte, 1'b0});
            packed_q.push_back(packed_byte_type'{8'(fill_cnt), 1'b1});
            fill_byte = '0;
            fill_cnt  = 0;
         end
         default: ;
      endcase
   endtask

   task automatic push_req(input logic [1:0] op, input sym_type sym,
                           input code_type code, input len_type len);
      request_q.push_back(req_beat_type'{op, sym, code, len, 1'b0});
      if (op == hbp_pkg::OP_LOAD && !gen_written[sym]) begin
         gen_written[sym] = 1'b1;
         loaded_syms.push_back(sym);
      end
   endtask

   // Mostly short codes, some long, some overlong, a few empty
   function automatic len_type pick_len();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r <= 2) return len_type'($urandom_range(33, 63));
      if (r <= 5) return len_type'($urandom_range(13, 32));
      return len_type'($urandom_range(1, 12));
   endfunction

   // Request side: predict on each accepted beat
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         pack_request(request_q.pop_front());
         offering = 1'b0;
      end
   end

   // Request driver with random idle bursts
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!offering) begin
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (request_q.size() > 0) begin
            if (request_q[0].steady) steady_mode = 1'b1;
            if (!steady_mode && $urandom_range(0, 99) < jitter_pct) begin
               req_gap = $urandom_range(1, 10) - 1;
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.operation   <= request_q[0].op;
               req_ch.symbol      <= request_q[0].sym;
               req_ch.code_bits   <= request_q[0].code;
               req_ch.code_length <= request_q[0].len;
               req_ch.valid       <= 1'b1;
               offering = 1'b1;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response sink: random stalls, one long hold to back up the block
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         jitter_cyc++;
         if (jitter_cyc % 128 == 0) begin
            case ($urandom_range(0, 2))
               0: jitter_pct = 0;
               1: jitter_pct = 10;
               default: jitter_pct = 35;
            endcase
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && beats_out >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_cnt  = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else if (!steady_mode && $urandom_range(0, 99) < jitter_pct) begin
            rsp_stall = $urandom_range(1, 10) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Response monitor: compare each beat with the oldest predicted byte
   always @(posedge clock) begin
      packed_byte_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         beats_out++;
         if (packed_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat byte=%02h last=%0b",
                                    rsp_ch.out_byte, rsp_ch.last));
         end else begin
            want = packed_q.pop_front();
            if (rsp_ch.out_byte !== want.data)
               flag_mismatch($sformatf("out_byte %02h, want %02h",
                                       rsp_ch.out_byte, want.data));
            if (rsp_ch.last !== want.last)
               flag_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                       rsp_ch.last, want.last, want.data));
         end
      end
   end

   // Watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("TIMEOUT: no beat for %0d cycles, %0d bytes outstanding",
                     IDLE_LIMIT, packed_q.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int nl;
      int nenc;
      int first_steady;

      clock       = 1'b0;
      reset       = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.operation   = hbp_pkg::OP_LOAD;
      req_ch.symbol      = '0;
      req_ch.code_bits   = '0;
      req_ch.code_length = '0;
      rsp_ch.ready       = 1'b0;
      fill_byte   = '0;
      fill_cnt    = 0;
      mismatches  = 0;
      beats_out   = 0;
      idle_cycles = 0;
      jitter_pct  = 10;
      jitter_cyc  = 0;
      steady_mode = 1'b0;
      offering    = 1'b0;
      req_gap     = 0;
      rsp_stall   = 0;
      hold_cnt    = 0;
      hold_done   = 1'b0;

      // Directed: table extremes, empty flush, long codes, masking, saturation
      push_req(hbp_pkg::OP_LOAD,   8'h00, 32'h0000_0001, 6'd1);
      push_req(hbp_pkg::OP_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32);
      push_req(hbp_pkg::OP_LOAD,   8'h80, 32'hDEAD_BEEF, 6'd0);   // zero-length code
      push_req(hbp_pkg::OP_LOAD,   8'h55, 32'hA5A5_A5A5, 6'd63);  // overlong length saturates
      push_req(hbp_pkg::OP_LOAD,   8'hAA, 32'hFFFF_FF35, 6'd7);   // high bits masked off
      push_req(hbp_pkg::OP_LOAD,   8'h01, 32'h0000_0000, 6'd8);
      push_req(hbp_pkg::OP_FLUSH,  8'h00, 32'h0, 6'd0);           // flush with nothing pending
      push_req(hbp_pkg::OP_ENCODE, 8'h00, 32'h0, 6'd0);
      push_req(hbp_pkg::OP_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'h3F);
      push_req(hbp_pkg::OP_ENCODE, 8'hFF, 32'h0, 6'd0);           // four whole bytes
      push_req(hbp_pkg::OP_ENCODE, 8'h00, 32'h0, 6'd0);
      push_req(hbp_pkg::OP_ENCODE, 8'hFF, 32'h0, 6'd0);           // straddles byte boundary
      push_req(hbp_pkg::OP_ENCODE, 8'h55, 32'h0, 6'd0);
      push_req(hbp_pkg::OP_ENCODE, 8'h80, 32'h0, 6'd0);           // appends nothing
      push_req(OP_UNUSED,          8'hFF, 32'hFFFF_FFFF, 6'h3F);  // ignored opcode
      push_req(hbp_pkg::OP_ENCODE, 8'hAA, 32'h0, 6'd0);
      push_req(hbp_pkg::OP_ENCODE, 8'h01, 32'h0, 6'd0);
      push_req(hbp_pkg::OP_ENCODE, 8'hAA, 32'h0, 6'd0);
      push_req(hbp_pkg::OP_ENCODE, 8'hFF, 32'h0, 6'd0);           // 7 pending + 32 bits
      push_req(hbp_pkg::OP_FLUSH,  8'h00, 32'h0, 6'd0);
      push_req(hbp_pkg::OP_LOAD,   8'h00, 32'h0000_001F, 6'd5);   // overwrite an entry
      push_req(hbp_pkg::OP_ENCODE, 8'h00, 32'h0, 6'd0);
      push_req(hbp_pkg::OP_FLUSH,  8'h00, 32'h0, 6'd0);

      // Random messages: table updates, a run of encodes, usually a flush
      while (request_q.size() < N_ITEMS - 1) begin
         nl = $urandom_range(0, (loaded_syms.size() < 16) ? 4 : 1);
         for (int j = 0; j < nl; j++)
            push_req(hbp_pkg::OP_LOAD, sym_type'($urandom), $urandom, pick_len());
         nenc = $urandom_range(1, 14);
         for (int j = 0; j < nenc; j++) begin
            if ($urandom_range(0, 29) == 0)
               push_req(OP_UNUSED, sym_type'($urandom), $urandom, len_type'($urandom));
            push_req(hbp_pkg::OP_ENCODE,
                     loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                     $urandom, len_type'($urandom));
         end
         if ($urandom_range(0, 5) != 0)
            push_req(hbp_pkg::OP_FLUSH, sym_type'($urandom), $urandom, len_type'($urandom));
      end
      push_req(hbp_pkg::OP_FLUSH, sym_type'($urandom), $urandom, len_type'($urandom));

      // Tail of the run goes without idling on either side
      first_steady = request_q.size() - N_STEADY;
      for (int i = first_steady; i < request_q.size(); i++)
         request_q[i].steady = 1'b1;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || packed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
